// ===== src/bgce_pkg.sv =====
// Shared types and constants for the box to grid cell enumerator.
// No dependencies; every other file in src imports this package.
package bgce_pkg;

    localparam int COORD_BITS      = 16;
    localparam int DEF_MAX_COLUMNS = 8;
    localparam int DEF_MAX_ROWS    = 8;

    localparam int POS_W    = COORD_BITS;
    localparam int BOX_W    = 15;
    localparam int CORNER_W = POS_W + 2;      // signed corner, exact
    localparam int MAG_W    = CORNER_W - 1;   // magnitude of a corner
    localparam int SIZE_W   = 16;
    localparam int ACC_W    = SIZE_W + 4;     // up to eight cell sizes
    localparam int CNT_W    = 4;              // grid_columns / grid_rows
    localparam int QUO_W    = 4;              // quotient 0..8
    localparam int CELL_W   = 3;
    localparam int IDX_W    = 6;
    localparam int STEP_W   = 3;

    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 16;
    localparam int OUT_USER_W = 2;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_GRID_COLUMNS = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_GRID_ROWS    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_CELL_WIDTH   = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_CELL_HEIGHT  = 2'd3;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    // One classified object: clamped cell range plus flags.
    typedef struct packed {
        logic [CELL_W-1:0] xs;
        logic [CELL_W-1:0] xe;
        logic [CELL_W-1:0] ys;
        logic [CELL_W-1:0] ye;
        logic              ovf;
        logic              single;   // emit one overflow-only result
    } t_job;

endpackage

// ===== src/box_to_grid_cell_enumerator_top.sv =====
// Top level of the box to grid cell enumerator: configuration registers,
// front end, job queue and back end. Uses bgce_pkg and the bgce_* modules.
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+------------------------------------
//   s stream | in        | i_s_tvalid/o_s_tready | tdata: pos_x, pos_y, box_w, box_h
//   m stream | out       | o_m_tvalid/i_m_tready | tdata: col,row,index; tuser; tlast
//   config   | in        | i_cfg_we              | i_cfg_addr, i_cfg_wdata
//
// Front end: an accept state, max(MAX_COLUMNS, MAX_ROWS) divide steps (8 by
// default) in the shared accumulate-and-compare loop, then a queue push state
// that holds while the queue is full; an unconfigured grid skips the divide
// steps. Back end: loads a job, then one result per cycle while the receiver
// is ready, up to 64 per box. The queue overlaps the divide of the next box
// with the cell walk of the current one.
// Reset is synchronous, active low; it clears the registers and empties the queue.
// Either stream may stall at any time; results wait in the output register.
module box_to_grid_cell_enumerator_top import bgce_pkg::*; #(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // [15:0] pos_x, [31:16] pos_y, [46:32] box_width, [61:47] box_height, zero pad
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // [2:0] cell_column, [5:3] cell_row, [11:6] cell_index, zero pad
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    // [0] cell_valid, [1] overflow_member
    output logic [OUT_USER_W-1:0] o_m_tuser,
    output logic                  o_m_tlast,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    logic [CNT_W-1:0]  r_grid_cols, r_grid_rows;
    logic [SIZE_W-1:0] r_cell_w, r_cell_h;
    logic [CNT_W-1:0]  cols_sat, rows_sat;

    logic              q_push, q_full, q_pop, q_empty;
    t_job              front_job, queue_job;

    logic [CELL_W-1:0] out_col, out_row;
    logic [IDX_W-1:0]  out_idx;
    logic              out_cval, out_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_cols <= '0;
            r_grid_rows <= '0;
            r_cell_w    <= '0;
            r_cell_h    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_GRID_COLUMNS: r_grid_cols <= i_cfg_wdata[CNT_W-1:0];
                REG_GRID_ROWS:    r_grid_rows <= i_cfg_wdata[CNT_W-1:0];
                REG_CELL_WIDTH:   r_cell_w    <= i_cfg_wdata[SIZE_W-1:0];
                REG_CELL_HEIGHT:  r_cell_h    <= i_cfg_wdata[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // saturate oversized grid counts
    assign cols_sat = (r_grid_cols > CNT_W'(MAX_COLUMNS)) ? CNT_W'(MAX_COLUMNS) : r_grid_cols;
    assign rows_sat = (r_grid_rows > CNT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : r_grid_rows;

    bgce_front #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_tvalid),
        .o_ready      (o_s_tready),
        .i_pos_x      (i_s_tdata[POS_W-1:0]),
        .i_pos_y      (i_s_tdata[2*POS_W-1:POS_W]),
        .i_box_width  (i_s_tdata[2*POS_W+BOX_W-1:2*POS_W]),
        .i_box_height (i_s_tdata[2*POS_W+2*BOX_W-1:2*POS_W+BOX_W]),
        .i_cols       (cols_sat),
        .i_rows       (rows_sat),
        .i_cell_w     (r_cell_w),
        .i_cell_h     (r_cell_h),
        .o_push       (q_push),
        .o_job        (front_job),
        .i_full       (q_full)
    );

    bgce_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_job   (queue_job),
        .o_empty (q_empty)
    );

    bgce_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (queue_job),
        .i_empty      (q_empty),
        .o_pop        (q_pop),
        .i_cols       (cols_sat),
        .o_valid      (o_m_tvalid),
        .i_ready      (i_m_tready),
        .o_col        (out_col),
        .o_row        (out_row),
        .o_idx        (out_idx),
        .o_cell_valid (out_cval),
        .o_ovf        (out_ovf),
        .o_last       (o_m_tlast)
    );

    assign o_m_tdata = OUT_DATA_W'({out_idx, out_row, out_col});
    assign o_m_tuser = {out_ovf, out_cval};

endmodule

// ===== src/bgce_front.sv =====
// Front end: accepts a box, divides its corners by the cell size with a
// shared multiple-accumulate compare loop, and classifies it. Uses bgce_pkg.
module bgce_front import bgce_pkg::*; #(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [POS_W-1:0]  i_pos_x,
    input  logic [POS_W-1:0]  i_pos_y,
    input  logic [BOX_W-1:0]  i_box_width,
    input  logic [BOX_W-1:0]  i_box_height,
    input  logic [CNT_W-1:0]  i_cols,
    input  logic [CNT_W-1:0]  i_rows,
    input  logic [SIZE_W-1:0] i_cell_w,
    input  logic [SIZE_W-1:0] i_cell_h,
    output logic              o_push,
    output t_job              o_job,
    input  logic              i_full
);

    localparam int STEPS = (MAX_COLUMNS > MAX_ROWS) ? MAX_COLUMNS : MAX_ROWS;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_PUSH = 2'd2;

    // lanes: 0 = x0, 1 = y0, 2 = x1, 3 = y1
    logic [1:0]        r_state, n_state;
    logic [MAG_W-1:0]  r_mag [4];
    logic [MAG_W-1:0]  n_mag [4];
    logic [3:0]        r_neg, n_neg;
    logic [QUO_W-1:0]  r_q [4];
    logic [QUO_W-1:0]  n_q [4];
    logic [ACC_W-1:0]  r_acc_x, n_acc_x, r_acc_y, n_acc_y;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_unconf, n_unconf;

    logic signed [CORNER_W-1:0] corner [4];
    logic [3:0]        on;
    logic [CELL_W-1:0] xs, xe, ys, ye;
    logic              unconf_now;
    logic [QUO_W-1:0]  lane_cnt [4];

    assign corner[0] = CORNER_W'(signed'(i_pos_x));
    assign corner[1] = CORNER_W'(signed'(i_pos_y));
    assign corner[2] = CORNER_W'(signed'(i_pos_x)) + CORNER_W'({1'b0, i_box_width});
    assign corner[3] = CORNER_W'(signed'(i_pos_y)) + CORNER_W'({1'b0, i_box_height});

    assign unconf_now = (i_cols == '0) || (i_rows == '0) ||
                        (i_cell_w == '0) || (i_cell_h == '0);

    assign lane_cnt[0] = i_cols;
    assign lane_cnt[1] = i_rows;
    assign lane_cnt[2] = i_cols;
    assign lane_cnt[3] = i_rows;

    // A negative corner is on the grid only while its quotient truncates to 0.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            on[i] = r_neg[i] ? (r_q[i] == '0) : (r_q[i] < lane_cnt[i]);
        end
        xs = on[0] ? r_q[0][CELL_W-1:0] : '0;
        ys = on[1] ? r_q[1][CELL_W-1:0] : '0;
        xe = on[2] ? r_q[2][CELL_W-1:0] : CELL_W'(i_cols - 1'b1);
        ye = on[3] ? r_q[3][CELL_W-1:0] : CELL_W'(i_rows - 1'b1);
    end

    always_comb begin
        o_job.xs     = xs;
        o_job.xe     = xe;
        o_job.ys     = ys;
        o_job.ye     = ye;
        o_job.ovf    = 1'b1;
        o_job.single = 1'b1;
        if (!r_unconf) begin
            o_job.ovf    = (on != 4'hF);
            o_job.single = (on == 4'h0) || (xs > xe) || (ys > ye);
        end
    end

    assign o_ready = (r_state == ST_IDLE);
    assign o_push  = (r_state == ST_PUSH) && !i_full;

    always_comb begin
        n_state  = r_state;
        n_mag    = r_mag;
        n_neg    = r_neg;
        n_q      = r_q;
        n_acc_x  = r_acc_x;
        n_acc_y  = r_acc_y;
        n_step   = r_step;
        n_unconf = r_unconf;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    for (int i = 0; i < 4; i++) begin
                        n_neg[i] = corner[i][CORNER_W-1];
                        n_mag[i] = corner[i][CORNER_W-1] ? MAG_W'(-corner[i])
                                                         : MAG_W'(corner[i]);
                        n_q[i]   = '0;
                    end
                    n_acc_x  = '0;
                    n_acc_y  = '0;
                    n_step   = '0;
                    n_unconf = unconf_now;
                    n_state  = unconf_now ? ST_PUSH : ST_DIV;
                end
            end
            ST_DIV: begin
                // accumulate one more cell size; count multiples not above |corner|
                n_acc_x = r_acc_x + ACC_W'(i_cell_w);
                n_acc_y = r_acc_y + ACC_W'(i_cell_h);
                for (int i = 0; i < 4; i++) begin
                    if (ACC_W'(r_mag[i]) >= ((i % 2 == 0) ? n_acc_x : n_acc_y)) begin
                        n_q[i] = QUO_W'(r_step) + 1'b1;
                    end
                end
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(STEPS - 1)) begin
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (!i_full) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_mag    <= n_mag;
        r_neg    <= n_neg;
        r_q      <= n_q;
        r_acc_x  <= n_acc_x;
        r_acc_y  <= n_acc_y;
        r_step   <= n_step;
        r_unconf <= n_unconf;
    end

    a_push_has_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && !o_job.single |-> (o_job.xs <= o_job.xe) && (o_job.ys <= o_job.ye))
        else $error("front: pushed an empty cell range");

    a_div_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) && (r_step == STEP_W'(STEPS - 1)) |=> (r_state == ST_PUSH))
        else $error("front: divide loop did not finish on the last step");

endmodule

// ===== src/bgce_queue.sv =====
// Short job queue between front end and back end, kept in flops.
// Uses bgce_pkg for the job type and depth.
module bgce_queue import bgce_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty
);

    t_job               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wp, r_rp;
    logic [Q_CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("queue: push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("queue: pop while empty");

endmodule

// ===== src/bgce_back.sv =====
// Back end: walks the clamped cell range column by column, each column row
// by row, one cell per transfer, through an output register. Uses bgce_pkg.
module bgce_back import bgce_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_job              i_job,
    input  logic              i_empty,
    output logic              o_pop,
    input  logic [CNT_W-1:0]  i_cols,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [CELL_W-1:0] o_col,
    output logic [CELL_W-1:0] o_row,
    output logic [IDX_W-1:0]  o_idx,
    output logic              o_cell_valid,
    output logic              o_ovf,
    output logic              o_last
);

    logic              r_busy, n_busy;
    t_job              r_job, n_job;
    logic [CELL_W-1:0] r_x, n_x, r_y, n_y;
    logic              r_vld, n_vld;
    logic [CELL_W-1:0] r_col, n_col, r_row, n_row;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic              r_cval, n_cval, r_ovf, n_ovf, r_last, n_last;

    logic              out_free;
    logic              at_end;
    logic [CELL_W+CNT_W-1:0] idx_full;

    assign out_free = !r_vld || i_ready;
    assign o_pop    = !r_busy && !i_empty;
    assign at_end   = (r_x == r_job.xe) && (r_y == r_job.ye);
    assign idx_full = (CELL_W+CNT_W)'(r_y) * (CELL_W+CNT_W)'(i_cols)
                    + (CELL_W+CNT_W)'(r_x);

    always_comb begin
        n_busy = r_busy;
        n_job  = r_job;
        n_x    = r_x;
        n_y    = r_y;
        n_vld  = r_vld && !i_ready;
        n_col  = r_col;
        n_row  = r_row;
        n_idx  = r_idx;
        n_cval = r_cval;
        n_ovf  = r_ovf;
        n_last = r_last;
        if (o_pop) begin
            n_busy = 1'b1;
            n_job  = i_job;
            n_x    = i_job.xs;
            n_y    = i_job.ys;
        end else if (r_busy && out_free) begin
            n_vld = 1'b1;
            if (r_job.single) begin
                n_col  = '0;
                n_row  = '0;
                n_idx  = '0;
                n_cval = 1'b0;
                n_ovf  = 1'b1;
                n_last = 1'b1;
                n_busy = 1'b0;
            end else begin
                n_col  = r_x;
                n_row  = r_y;
                n_idx  = idx_full[IDX_W-1:0];
                n_cval = 1'b1;
                n_ovf  = r_job.ovf;
                n_last = at_end;
                // advance row first, then column
                if (at_end) begin
                    n_busy = 1'b0;
                end else if (r_y == r_job.ye) begin
                    n_y = r_job.ys;
                    n_x = r_x + 1'b1;
                end else begin
                    n_y = r_y + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_vld  <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_vld  <= n_vld;
        end
        r_job  <= n_job;
        r_x    <= n_x;
        r_y    <= n_y;
        r_col  <= n_col;
        r_row  <= n_row;
        r_idx  <= n_idx;
        r_cval <= n_cval;
        r_ovf  <= n_ovf;
        r_last <= n_last;
    end

    assign o_valid      = r_vld;
    assign o_col        = r_col;
    assign o_row        = r_row;
    assign o_idx        = r_idx;
    assign o_cell_valid = r_cval;
    assign o_ovf        = r_ovf;
    assign o_last       = r_last;

    a_mid_run_is_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld && !r_last |-> r_cval)
        else $error("back: non-final result without a valid cell");

    a_no_cell_is_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld && !r_cval |-> r_ovf && r_last)
        else $error("back: cell-less result must be a lone overflow result");

endmodule

// ===== tb/box_to_grid_cell_enumerator_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for box_to_grid_cell_enumerator_top: streams boxes in,
// predicts every covered grid cell per box and checks each result transfer.
// Depends on bgce_pkg and the RTL under src only.
module box_to_grid_cell_enumerator_top_tb import bgce_pkg::*;;

    localparam int MAX_COLS       = DEF_MAX_COLUMNS;
    localparam int MAX_ROWS_P     = DEF_MAX_ROWS;
    localparam int SETTLE_CYCLES  = 16;
    localparam int TAIL_CYCLES    = 64;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 110;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [CELL_W-1:0] col;
        logic [CELL_W-1:0] row;
        logic [IDX_W-1:0]  cell_idx;
        logic              valid;
        logic              ovf;
        logic              last;
    } t_grid_cell;

    // Mirror of the grid registers plus the cells still owed by the block.
    class cell_ledger;
        logic [CNT_W-1:0]  grid_cols;
        logic [CNT_W-1:0]  grid_rows;
        logic [SIZE_W-1:0] cell_w;
        logic [SIZE_W-1:0] cell_h;
        t_grid_cell        due_cells[$];
        int                failures;

        function new();
            grid_cols = '0;
            grid_rows = '0;
            cell_w    = '0;
            cell_h    = '0;
            failures  = 0;
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] value);
            case (addr)
                REG_GRID_COLUMNS: grid_cols = value[CNT_W-1:0];
                REG_GRID_ROWS:    grid_rows = value[CNT_W-1:0];
                REG_CELL_WIDTH:   cell_w    = value;
                REG_CELL_HEIGHT:  cell_h    = value;
                default: ;
            endcase
        endfunction

        function int pending();
            return due_cells.size();
        endfunction

        // Quotient truncates toward zero; -1 marks an off-grid coordinate.
        function int grid_slot(int coord, int size, int count);
            int q;
            q = coord / size;
            return (q >= 0 && q < count) ? q : -1;
        endfunction

        function void push_cell(int col, int row, int cell_idx, logic valid, logic ovf,
                                logic last);
            t_grid_cell c;
            c.col      = CELL_W'(col);
            c.row      = CELL_W'(row);
            c.cell_idx = IDX_W'(cell_idx);
            c.valid    = valid;
            c.ovf      = ovf;
            c.last     = last;
            due_cells  = {due_cells, c};
        endfunction

        function void note_box(logic [IN_DATA_W-1:0] data);
            logic signed [POS_W-1:0] pos_x;
            logic signed [POS_W-1:0] pos_y;
            int cols, rows, x0, y0, x1, y1, ulx, uly, lrx, lry, xs, xe, ys, ye, n;
            logic ovf;
            t_grid_cell tail;
            pos_x = data[15:0];
            pos_y = data[31:16];
            cols  = (grid_cols > MAX_COLS) ? MAX_COLS : int'(grid_cols);
            rows  = (grid_rows > MAX_ROWS_P) ? MAX_ROWS_P : int'(grid_rows);
            if (cols == 0 || rows == 0 || cell_w == 0 || cell_h == 0) begin
                push_cell(0, 0, 0, 1'b0, 1'b1, 1'b1);
                return;
            end
            x0  = pos_x;
            y0  = pos_y;
            x1  = x0 + int'(data[46:32]);
            y1  = y0 + int'(data[61:47]);
            ulx = grid_slot(x0, int'(cell_w), cols);
            uly = grid_slot(y0, int'(cell_h), rows);
            lrx = grid_slot(x1, int'(cell_w), cols);
            lry = grid_slot(y1, int'(cell_h), rows);
            ovf = (ulx < 0 || uly < 0 || lrx < 0 || lry < 0);
            if (ulx < 0 && uly < 0 && lrx < 0 && lry < 0) begin
                push_cell(0, 0, 0, 1'b0, 1'b1, 1'b1);
                return;
            end
            // Clamp off-grid corners to the grid edges, even past the far edge.
            xs = (ulx >= 0) ? ulx : 0;
            xe = (lrx >= 0) ? lrx : cols - 1;
            ys = (uly >= 0) ? uly : 0;
            ye = (lry >= 0) ? lry : rows - 1;
            n  = 0;
            for (int x = xs; x <= xe; x++) begin
                for (int y = ys; y <= ye; y++) begin
                    if (n < 64) begin
                        push_cell(x, y, y * cols + x, 1'b1, ovf, 1'b0);
                        n++;
                    end
                end
            end
            if (n == 0) begin
                push_cell(0, 0, 0, 1'b0, 1'b1, 1'b1);
            end else begin
                tail      = due_cells.pop_back();
                tail.last = 1'b1;
                due_cells = {due_cells, tail};
            end
        endfunction

        function void complain(string what, t_grid_cell want, t_grid_cell got);
            failures++;
            if (failures <= REPORT_LIMIT) begin
                $display("%0t %s: expected col %0d row %0d idx %0d valid %b ovf %b last %b",
                         $time, what, want.col, want.row, want.cell_idx, want.valid,
                         want.ovf, want.last);
                $display("%0t %s:      got col %0d row %0d idx %0d valid %b ovf %b last %b",
                         $time, what, got.col, got.row, got.cell_idx, got.valid,
                         got.ovf, got.last);
            end
        endfunction

        function void check_cell(logic [OUT_DATA_W-1:0] data, logic [OUT_USER_W-1:0] user,
                                 logic last);
            t_grid_cell got, want;
            got.col      = data[2:0];
            got.row      = data[5:3];
            got.cell_idx = data[11:6];
            got.valid    = user[0];
            got.ovf      = user[1];
            got.last     = last;
            if (due_cells.size() == 0) begin
                complain("result with no box pending", '0, got);
                return;
            end
            want = due_cells.pop_front();
            if (got !== want)
                complain("cell mismatch", want, got);
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata;    // [15:0] pos_x, [31:16] pos_y, [46:32] box_width,
                                         // [61:47] box_height, zero pad
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [OUT_DATA_W-1:0] o_m_tdata;    // [2:0] cell_column, [5:3] cell_row,
                                         // [11:6] cell_index, zero pad
    logic [OUT_USER_W-1:0] o_m_tuser;    // [0] cell_valid, [1] overflow_member
    logic                  o_m_tlast;
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    cell_ledger ledger;
    logic       idling;
    int         quiet_cycles;
    int         sent_random;
    int         items;

    box_to_grid_cell_enumerator_top #(
        .MAX_COLUMNS (MAX_COLS),
        .MAX_ROWS    (MAX_ROWS_P)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Receiver: random stall bursts while idling is on.
    initial begin
        forever begin
            @(negedge i_clk);
            if (idling && $urandom_range(4) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(7, 1)) @(negedge i_clk);
            end
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready)
                ledger.check_cell(o_m_tdata, o_m_tuser, o_m_tlast);
            if (i_s_tvalid && o_s_tready)
                ledger.note_box(i_s_tdata);
            if (i_cfg_we)
                ledger.write_reg(i_cfg_addr, i_cfg_wdata);
            if ((o_m_tvalid && i_m_tready) || (i_s_tvalid && o_s_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("Test completed with failures");
                    $finish;
                end
            end
        end
    end

    task automatic send_box(input int px, input int py, input int bw, input int bh);
        @(negedge i_clk);
        if (idling && $urandom_range(3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(7, 1)) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {2'b00, BOX_W'(bh), BOX_W'(bw), POS_W'(py), POS_W'(px)};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    // Drop valid and hold until every owed cell has come back.
    task automatic drain();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (ledger.pending() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_beat(input logic [CFG_ADDR_W-1:0] addr,
                            input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= value;
    endtask

    task automatic set_grid(input int cols, input int rows, input int cw, input int ch);
        drain();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        cfg_beat(REG_GRID_COLUMNS, CFG_DATA_W'(cols));
        cfg_beat(REG_GRID_ROWS,    CFG_DATA_W'(rows));
        cfg_beat(REG_CELL_WIDTH,   CFG_DATA_W'(cw));
        cfg_beat(REG_CELL_HEIGHT,  CFG_DATA_W'(ch));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Position from just before the grid to just past its far edge.
    function automatic logic [POS_W-1:0] near_grid(int span, int cell_size);
        int lo, hi;
        lo = (-cell_size < -32768) ? -32768 : -cell_size;
        hi = (span + cell_size > 32767) ? 32767 : span + cell_size;
        return POS_W'(lo + int'($urandom_range(hi - lo)));
    endfunction

    task automatic send_random_box();
        int cols, rows, span_x, span_y;
        logic [POS_W-1:0] px, py;
        logic [BOX_W-1:0] bw, bh;
        if ($urandom_range(3) == 0) begin
            px = POS_W'($urandom);
            py = POS_W'($urandom);
            bw = BOX_W'($urandom);
            bh = BOX_W'($urandom);
        end else begin
            cols   = (ledger.grid_cols > MAX_COLS) ? MAX_COLS : int'(ledger.grid_cols);
            rows   = (ledger.grid_rows > MAX_ROWS_P) ? MAX_ROWS_P : int'(ledger.grid_rows);
            span_x = ((cols == 0) ? 1 : cols) * int'(ledger.cell_w);
            span_y = ((rows == 0) ? 1 : rows) * int'(ledger.cell_h);
            px = near_grid(span_x, int'(ledger.cell_w));
            py = near_grid(span_y, int'(ledger.cell_h));
            bw = BOX_W'($urandom_range((span_x > 32767) ? 32767 : span_x));
            bh = BOX_W'($urandom_range((span_y > 32767) ? 32767 : span_y));
        end
        send_box(int'(px), int'(py), int'(bw), int'(bh));
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = '0;
        i_m_tready   = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_addr   = '0;
        i_cfg_wdata  = '0;
        idling       = 1'b1;
        quiet_cycles = 0;
        sent_random  = 0;
        ledger       = new();
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Unconfigured grid straight out of reset: one overflow-only result each.
        send_box(0, 0, 0, 0);
        send_box(32767, -32768, 32767, 32767);

        set_grid(8, 8, 10, 10);
        send_box(0, 0, 0, 0);
        send_box(0, 0, 79, 79);
        send_box(-5, -5, 10, 10);                 // small negative truncates onto row 0
        send_box(-15, -15, 20, 20);               // upper-left off grid, clamp to 0
        send_box(75, 75, 100, 100);               // lower-right past far edge
        send_box(-32768, -32768, 32767, 32767);
        send_box(32767, 32767, 32767, 32767);     // entirely off grid
        send_box(100, 5, 0, 0);                   // both x corners past far edge
        send_box(-32768, 5, 0, 0);                // both x corners negative
        send_box(25, -32768, 10, 32767);

        // Oversized column count saturates; unit cell width.
        set_grid(15, 1, 1, 65535);
        send_box(0, 0, 7, 0);
        send_box(-1, 0, 32767, 32767);
        send_box(7, 32767, 0, 0);

        set_grid(1, 15, 65535, 1);
        send_box(0, 3, 0, 4);
        send_box(32767, -32768, 32767, 32767);

        set_grid(8, 8, 0, 5);
        send_box(0, 0, 0, 0);
        set_grid(0, 8, 5, 5);
        send_box(0, 0, 0, 0);
        set_grid(8, 0, 5, 0);
        send_box(0, 0, 0, 0);

        set_grid(8, 8, 4096, 4096);
        send_box(-32768, -32768, 32767, 32767);
        send_box(32767, 0, 0, 0);

        while (sent_random < RANDOM_ITEMS) begin
            set_grid(($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(8, 1),
                     ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(8, 1),
                     ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(64, 1),
                     ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(64, 1));
            idling = ($urandom_range(3) != 0);
            items  = $urandom_range(28, 12);
            repeat (items) begin
                if ($urandom_range(24) == 0)
                    drain();
                send_random_box();
            end
            sent_random += items;
        end

        // Back-to-back tail with no stalls on either side.
        set_grid(8, 8, 16, 16);
        idling = 1'b0;
        repeat (30) send_random_box();

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (ledger.failures == 0 && ledger.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
